[hw/rtl/byte_stuffed_frame_encoder_defines.svh]
// assertion macros for the byte stuffed frame encoder
// no dependencies; included by the modules that carry assertions
`ifndef BYTE_STUFFED_FRAME_ENCODER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define BSFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bsfe assertion failed");
`define BSFE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bsfe forbidden condition");
`else
`define BSFE_ASSERT(lbl, clk, rstn, prop)
`define BSFE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hw/rtl/bsfe_pkg.sv]
// shared constants, types and helpers of the byte stuffed frame encoder
// no dependencies
package bsfe_pkg;

  localparam logic [7:0] CODE_START  = 8'hAA;
  localparam logic [7:0] CODE_STOP   = 8'hAB;
  localparam logic [7:0] CODE_ESCAPE = 8'hAC;

  localparam int unsigned RunLen = 8;
  localparam int unsigned CntW   = $clog2(RunLen + 1);
  localparam int unsigned PtrW   = $clog2(RunLen);
  localparam int unsigned NumSym = 5;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  first;
    logic  last;
    byte_t addr;
    byte_t chk;
  } item_t;

  typedef struct packed {
    logic [RunLen-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
  } run_t;

  function automatic logic is_code(input byte_t b);
    return (b >= CODE_START) && (b <= CODE_ESCAPE);
  endfunction

endpackage

[hw/rtl/bsfe_in_stage.sv]
// input register: address register, running checksum and the request holding stage
// depends on bsfe_pkg
module bsfe_in_stage import bsfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  byte_t cfg_wdata_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t payload_byte_i,
  input  logic  first_byte_i,
  input  logic  last_byte_i,
  output item_t item_o,
  output logic  item_valid_o,
  input  logic  item_take_i
);

  byte_t addr_q;
  byte_t chk_q, chk_d;
  item_t item_q;
  logic  item_valid_q, item_valid_d;
  logic  accept;

  assign in_ready_o = !item_valid_q || item_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign chk_d      = (first_byte_i ? addr_q : chk_q) ^ payload_byte_i;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (item_take_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      chk_q        <= '0;
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (accept) begin
        chk_q <= chk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data  <= payload_byte_i;
      item_q.first <= first_byte_i;
      item_q.last  <= last_byte_i;
      item_q.addr  <= addr_q;
      item_q.chk   <= chk_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = item_valid_q;

endmodule

[hw/rtl/bsfe_expand.sv]
// builds the line byte run of one request: codes, escapes and byte count
// depends on bsfe_pkg
module bsfe_expand import bsfe_pkg::*; (
  input  item_t item_i,
  output run_t  run_o
);

  logic  [NumSym-1:0] sym_en;
  logic  [NumSym-1:0] sym_raw;
  byte_t [NumSym-1:0] sym_val;

  always_comb begin
    sym_en  = {item_i.last, item_i.last, 1'b1, item_i.first, item_i.first};
    sym_raw = {1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    sym_val[0] = CODE_START;
    sym_val[1] = item_i.addr;
    sym_val[2] = item_i.data;
    sym_val[3] = item_i.chk;
    sym_val[4] = CODE_STOP;
  end

  always_comb begin
    logic [CntW-1:0] n;
    logic [CntW-1:0] n1;
    run_o.bytes = '0;
    n           = '0;
    for (int i = 0; i < NumSym; i++) begin
      n1 = n + CntW'(1);
      if (sym_en[i]) begin
        if (!sym_raw[i] && is_code(sym_val[i])) begin
          run_o.bytes[n[PtrW-1:0]]  = CODE_ESCAPE;
          run_o.bytes[n1[PtrW-1:0]] = 8'(sym_val[i] - CODE_START);
          n = n + CntW'(2);
        end else begin
          run_o.bytes[n[PtrW-1:0]] = sym_val[i];
          n = n1;
        end
      end
    end
    run_o.count = n;
  end

endmodule

[hw/rtl/bsfe_out_seq.sv]
// result register: holds one run of line bytes and hands them out one per cycle while out_ready_i is high
// depends on bsfe_pkg and byte_stuffed_frame_encoder_defines.svh
`include "byte_stuffed_frame_encoder_defines.svh"
module bsfe_out_seq import bsfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  run_t  run_i,
  input  logic  run_valid_i,
  output logic  run_take_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t line_byte_o,
  output logic  end_of_run_o
);

  logic [RunLen-1:0][7:0] buf_q;
  logic [CntW-1:0]        cnt_q;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic                   valid_q, valid_d;
  logic                   last_beat;
  logic                   load;

  assign end_of_run_o = (CntW'(ptr_q) + CntW'(1)) == cnt_q;
  assign last_beat    = valid_q && out_ready_i && end_of_run_o;
  assign load         = run_valid_i && (!valid_q || last_beat);
  assign run_take_o   = load;
  assign out_valid_o  = valid_q;
  assign line_byte_o  = buf_q[ptr_q];

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (load) begin
      valid_d = 1'b1;
      ptr_d   = '0;
    end else if (last_beat) begin
      valid_d = 1'b0;
      ptr_d   = '0;
    end else if (valid_q && out_ready_i) begin
      ptr_d = ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= run_i.bytes;
      cnt_q <= run_i.count;
    end
  end

  `BSFE_ASSERT(a_ptr_in_run, clk_i, rst_ni, valid_q |-> (CntW'(ptr_q) < cnt_q))
  `BSFE_ASSERT(a_run_len, clk_i, rst_ni, valid_q |-> (cnt_q != '0 && cnt_q <= CntW'(RunLen)))
  `BSFE_ASSERT(a_drain_idle, clk_i, rst_ni, (last_beat && !load) |=> !valid_q)
  `BSFE_ASSERT_NEVER(a_load_busy, clk_i, rst_ni, load && valid_q && !last_beat)

endmodule

[hw/rtl/byte_stuffed_frame_encoder.sv]
// an accepted request is held in the input stage, then loaded into the result register
// throughput: one line byte per cycle while out_ready_i is high; a request gives 1 to 8 bytes
// the next request is loaded once the result register is empty or hands out its last byte
// reset: clears all handshake state; unit address and checksum reset to zero
module byte_stuffed_frame_encoder import bsfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  byte_t cfg_wdata_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  byte_t payload_byte_i,
  input  logic  first_byte_i,
  input  logic  last_byte_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t line_byte_o,
  output logic  end_of_run_o
);

  item_t item;
  logic  item_valid;
  logic  item_take;
  run_t  run;

  bsfe_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .payload_byte_i(payload_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_take_i   (item_take)
  );

  bsfe_expand u_expand (
    .item_i(item),
    .run_o (run)
  );

  bsfe_out_seq u_out_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .run_valid_i (item_valid),
    .run_take_o  (item_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .line_byte_o (line_byte_o),
    .end_of_run_o(end_of_run_o)
  );

endmodule
